>>> sv/wmsd_pkg.sv
// Package for the weighted mean surface distance block.
// Holds shared widths, the controller/datapath command and status structs.
package wmsd_pkg;

    localparam int FRAC = 16;
    localparam int WSUM_W = 27;
    localparam int XSUM_W = 58;

    localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};
    localparam logic signed [XSUM_W-1:0] XSUM_MAX = {1'b0, {(XSUM_W-1){1'b1}}};
    localparam logic signed [XSUM_W-1:0] XSUM_MIN = {1'b1, {(XSUM_W-1){1'b0}}};

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_CUTOFF = 2'd1;
    localparam logic [1:0] REG_FAR    = 2'd2;

    // Commands from the controller into the datapath
    typedef struct packed {
        logic load;      // latch item, start weight work
        logic wstep;     // one step of the weight chain
        logic accum;     // add weight into the sums
        logic fstart;    // start the final mean/root
        logic fstep;     // one step of the final chain
        logic emit;      // load output register and clear the run
    } wmsd_cmd_t;

    // Status back to the controller
    typedef struct packed {
        logic wdone;
        logic fdone;
    } wmsd_sts_t;

endpackage

>>> sv/wmsd_datapath.sv
// Datapath: kernel weight, accumulators, mean division and square root.
// Depends on wmsd_pkg; sequenced by wmsd_ctrl.
module wmsd_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  wmsd_pkg::wmsd_cmd_t cmd,
    output wmsd_pkg::wmsd_sts_t sts,
    input  logic [30:0]         kernel_radius,
    input  logic [16:0]         cutoff_threshold,
    input  logic [30:0]         far_value,
    input  logic signed [31:0]  qx_in,
    input  logic signed [31:0]  qy_in,
    input  logic signed [31:0]  px_in,
    input  logic signed [31:0]  py_in,
    input  logic                pvalid_in,
    output logic [33:0]         result
);
    localparam int F = wmsd_pkg::FRAC;

    // weight phase registers
    logic signed [31:0] px_reg, py_reg;
    logic signed [31:0] qx_reg, qy_reg;
    logic               pv_reg;
    logic [5:0]         wph_reg;
    logic [62:0]        rem_reg;
    logic [61:0]        r2_reg;
    logic [F:0]         s2_reg;
    logic [32:0]        ax_reg, ay_reg;
    logic [33:0]        t_reg;
    logic [33:0]        t2_reg;
    logic [33:0]        w_reg;
    logic               wzero_reg;
    logic signed [64:0] prx_reg, pry_reg;

    logic [wmsd_pkg::WSUM_W-1:0]        wsum_reg;
    logic signed [wmsd_pkg::XSUM_W-1:0] xsum_reg, ysum_reg;
    logic                               ovf_reg;

    // final phase registers
    logic [6:0]  fph_reg;
    logic [57:0] nx_reg, ny_reg;      // magnitudes being divided
    logic [57:0] qxq_reg, qyq_reg;    // quotients
    logic [27:0] rx_reg, ry_reg;      // remainders
    logic        sx_reg, sy_reg;
    logic [63:0] sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [32:0] ex_reg, ey_reg;
    logic [47:0] iso_reg;
    logic [33:0] result_reg;
    logic        wdone_reg, fdone_reg;

    logic signed [32:0] dx, dy;
    assign dx = 33'(qx_reg) - 33'(px_reg);
    assign dy = 33'(qy_reg) - 33'(py_reg);

    logic [62:0] rem_sh;
    assign rem_sh = {rem_reg[61:0], 1'b0};

    // weight times particle coordinate
    logic signed [17:0] w_s;
    logic signed [49:0] wpx, wpy;
    assign w_s = $signed({1'b0, w_reg[16:0]});
    assign wpx = 50'(w_s) * 50'(px_reg);
    assign wpy = 50'(w_s) * 50'(py_reg);

    // sums with saturation
    logic [wmsd_pkg::WSUM_W:0] wsum_add;
    logic signed [65:0] xs_add, ys_add;
    assign wsum_add = {1'b0, wsum_reg} + (wmsd_pkg::WSUM_W+1)'(w_reg);
    assign xs_add = 66'(xsum_reg) + 66'(prx_reg);
    assign ys_add = 66'(ysum_reg) + 66'(pry_reg);

    logic w_sat, x_hi, x_lo, y_hi, y_lo;
    assign w_sat = wsum_add[wmsd_pkg::WSUM_W] || (w_reg[33:27] != '0);
    assign x_hi = xs_add > 66'(wmsd_pkg::XSUM_MAX);
    assign x_lo = xs_add < 66'(wmsd_pkg::XSUM_MIN);
    assign y_hi = ys_add > 66'(wmsd_pkg::XSUM_MAX);
    assign y_lo = ys_add < 66'(wmsd_pkg::XSUM_MIN);

    // divide steps: restoring, one quotient bit per cycle each
    logic [58:0] dvx_t, dvy_t;
    assign dvx_t = {rx_reg, nx_reg[57]} - {32'd0, wsum_reg};
    assign dvy_t = {ry_reg, ny_reg[57]} - {32'd0, wsum_reg};

    // mean and coordinate error (combinational from quotients)
    logic signed [59:0] mx_full, my_full, mx_c, my_c;
    logic signed [60:0] ddx, ddy;
    localparam logic signed [59:0] LIM = 60'sh7FFFFFFF;
    assign mx_full = sx_reg ? -60'(qxq_reg) : 60'(qxq_reg);
    assign my_full = sy_reg ? -60'(qyq_reg) : 60'(qyq_reg);
    assign mx_c = (mx_full > LIM) ? LIM : ((mx_full < -LIM - 1) ? -LIM - 1 : mx_full);
    assign my_c = (my_full > LIM) ? LIM : ((my_full < -LIM - 1) ? -LIM - 1 : my_full);
    assign ddx = 61'(qx_reg) - 61'(mx_c);
    assign ddy = 61'(qy_reg) - 61'(my_c);

    function automatic logic [32:0] clmag(input logic signed [60:0] v);
        logic [60:0] m;
        begin
            m = v[60] ? 61'(-v) : 61'(v);
            clmag = (m > 61'h7FFFFFFF) ? 33'h7FFFFFFF : m[32:0];
        end
    endfunction

    // distance = len - iso, saturated
    logic signed [49:0] dist_full;
    logic [31:0] dist_sat;
    assign dist_full = 50'(sq_res_reg[32:0]) - 50'(iso_reg);
    assign dist_sat = (dist_full > 50'sh7FFFFFFF) ? 32'h7FFFFFFF :
                      ((dist_full < -50'sh80000000) ? 32'h80000000 : dist_full[31:0]);

    logic [63:0] sq_sum;
    assign sq_sum = sq_res_reg + sq_bit_reg;

    always_ff @(posedge aclk) begin
        // flag the cycle after the last step of each chain
        wdone_reg <= aresetn && cmd.wstep && (wph_reg >= 6'(7 + F));
        fdone_reg <= aresetn && cmd.fstep && (fph_reg >= 7'd93);
        // latch an item and start the weight chain
        if (cmd.load) begin
            qx_reg <= qx_in; qy_reg <= qy_in;
            px_reg <= px_in; py_reg <= py_in;
            pv_reg <= pvalid_in;
            wph_reg <= 6'd0;
        end
        // weight chain: magnitudes, squares, long division, cube, products
        if (cmd.wstep) begin
            wph_reg <= wph_reg + 6'd1;
            if (wph_reg == 6'd0) begin
                ax_reg <= dx[32] ? 33'(-dx) : 33'(dx);
                ay_reg <= dy[32] ? 33'(-dy) : 33'(dy);
            end else if (wph_reg == 6'd1) begin
                wzero_reg <= !pv_reg || (ax_reg >= 33'(kernel_radius)) ||
                             (ay_reg >= 33'(kernel_radius));
                rem_reg <= 63'(ax_reg[30:0]) * 63'(ax_reg[30:0]);
                r2_reg <= 62'(kernel_radius) * 62'(kernel_radius);
            end else if (wph_reg == 6'd2) begin
                rem_reg <= rem_reg + 63'(ay_reg[30:0]) * 63'(ay_reg[30:0]);
                s2_reg <= '0;
            end else if (wph_reg == 6'd3) begin
                if (rem_reg >= 63'(r2_reg)) wzero_reg <= 1'b1;
            end else if (wph_reg < 6'(4 + F)) begin
                if (rem_sh >= 63'(r2_reg)) begin
                    rem_reg <= rem_sh - 63'(r2_reg);
                    s2_reg <= {s2_reg[F-1:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    s2_reg <= {s2_reg[F-1:0], 1'b0};
                end
            end else if (wph_reg == 6'(4 + F)) begin
                t_reg <= 34'(1 << F) - 34'(s2_reg);
            end else if (wph_reg == 6'(5 + F)) begin
                t2_reg <= 34'((t_reg * t_reg) >> F);
            end else if (wph_reg == 6'(6 + F)) begin
                w_reg <= wzero_reg ? 34'd0 : 34'((t2_reg * t_reg) >> F);
            end else begin
                prx_reg <= 65'(wpx);
                pry_reg <= 65'(wpy);
            end
        end
        if (cmd.fstart) begin
            nx_reg <= xsum_reg[57] ? 58'(-xsum_reg) : 58'(xsum_reg);
            ny_reg <= ysum_reg[57] ? 58'(-ysum_reg) : 58'(ysum_reg);
            sx_reg <= xsum_reg[57];
            sy_reg <= ysum_reg[57];
            rx_reg <= '0; ry_reg <= '0;
            fph_reg <= '0;
            iso_reg <= (48'(cutoff_threshold) * 48'(kernel_radius)) >> F;
        end
        // final chain: 58 divide steps, error, square setup, 32 root steps
        if (cmd.fstep) begin
            fph_reg <= fph_reg + 7'd1;
            if (fph_reg < 7'd58) begin
                nx_reg <= {nx_reg[56:0], 1'b0};
                ny_reg <= {ny_reg[56:0], 1'b0};
                if (!dvx_t[58]) begin
                    rx_reg <= dvx_t[27:0]; qxq_reg <= {qxq_reg[56:0], 1'b1};
                end else begin
                    rx_reg <= {rx_reg[26:0], nx_reg[57]}; qxq_reg <= {qxq_reg[56:0], 1'b0};
                end
                if (!dvy_t[58]) begin
                    ry_reg <= dvy_t[27:0]; qyq_reg <= {qyq_reg[56:0], 1'b1};
                end else begin
                    ry_reg <= {ry_reg[26:0], ny_reg[57]}; qyq_reg <= {qyq_reg[56:0], 1'b0};
                end
            end else if (fph_reg == 7'd58) begin
                ex_reg <= clmag(ddx);
                ey_reg <= clmag(ddy);
            end else if (fph_reg == 7'd59) begin
                sq_v_reg <= 64'(ex_reg[30:0]) * 64'(ex_reg[30:0]);
            end else if (fph_reg == 7'd60) begin
                sq_v_reg <= sq_v_reg + 64'(ey_reg[30:0]) * 64'(ey_reg[30:0]);
                sq_res_reg <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
            end else if (fph_reg < 7'd93) begin
                if (sq_v_reg >= sq_sum) begin
                    sq_v_reg <= sq_v_reg - sq_sum;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
        end
        if (cmd.emit) begin
            if (wsum_reg == '0)
                result_reg <= {ovf_reg, 1'b1, 1'b0, far_value};
            else
                result_reg <= {ovf_reg, 1'b0, dist_sat};
        end
    end

    // accumulators: control state, cleared at reset and after each result
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.emit) begin
            wsum_reg <= '0;
            xsum_reg <= '0;
            ysum_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.accum) begin
            wsum_reg <= w_sat ? wmsd_pkg::WSUM_MAX : wsum_add[wmsd_pkg::WSUM_W-1:0];
            xsum_reg <= x_hi ? wmsd_pkg::XSUM_MAX :
                        (x_lo ? wmsd_pkg::XSUM_MIN : xs_add[57:0]);
            ysum_reg <= y_hi ? wmsd_pkg::XSUM_MAX :
                        (y_lo ? wmsd_pkg::XSUM_MIN : ys_add[57:0]);
            ovf_reg <= ovf_reg || w_sat || x_hi || x_lo || y_hi || y_lo;
        end
    end

    assign sts.wdone = wdone_reg;
    assign sts.fdone = fdone_reg;
    assign result = result_reg;
endmodule

>>> sv/wmsd_ctrl.sv
// Controller: sequences item load, weight steps, accumulate and final steps.
// Depends on wmsd_pkg; drives wmsd_datapath.
module wmsd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_last,
    output logic                out_valid,
    input  logic                out_ready,
    input  wmsd_pkg::wmsd_sts_t sts,
    output wmsd_pkg::wmsd_cmd_t cmd
);
    typedef enum logic [2:0] {IDLE, WEIGHT, ACCUM, FSTART, FINAL, EMIT} state_t;
    state_t state_reg;
    logic   last_reg;
    logic   ovalid_reg;

    assign in_ready = (state_reg == IDLE);
    assign out_valid = ovalid_reg;

    always_comb begin
        cmd = '0;
        cmd.load = in_valid && in_ready;
        cmd.wstep = (state_reg == WEIGHT) && !sts.wdone;
        cmd.accum = (state_reg == ACCUM);
        cmd.fstart = (state_reg == FSTART);
        cmd.fstep = (state_reg == FINAL) && !sts.fdone;
        cmd.emit = (state_reg == EMIT) && (!ovalid_reg || out_ready);
    end

    // step the sequence; hold a result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            last_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= cmd.emit || (ovalid_reg && !out_ready);
            unique case (state_reg)
                IDLE: if (in_valid) begin
                    last_reg <= in_last;
                    state_reg <= WEIGHT;
                end
                WEIGHT: if (sts.wdone) state_reg <= ACCUM;
                ACCUM: state_reg <= last_reg ? FSTART : IDLE;
                FSTART: state_reg <= FINAL;
                FINAL: if (sts.fdone) state_reg <= EMIT;
                EMIT: if (!ovalid_reg || out_ready) state_reg <= IDLE;
                default: state_reg <= IDLE;
            endcase
        end
    end

    a_one_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wstep && cmd.fstep)) else $error("weight and final overlap");
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> ovalid_reg) else $error("emit lost result");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != IDLE) |-> !cmd.load) else $error("accept while busy");
endmodule

>>> sv/weighted_mean_surface_distance.sv
// Top level of the weighted mean surface distance block.
// Depends on wmsd_pkg, wmsd_ctrl and wmsd_datapath.
//
// Usage: stream a run of items on s_axis (query, one particle or none,
// tlast on the final item). Each item is taken only in idle; the block then
// runs the weight chain, set by its 16-step division, accumulates and goes
// back to idle before it takes the next item. After the final item's
// accumulate, the block loads the mean division, runs two 58-step mean
// divisions in parallel, the error and a 32-step square root, and loads the
// output register. One result per run appears on m_axis and is held there
// until m_tready; the next run's items are taken while it waits, and a
// further result stalls in the sequencer until the held one is taken.
// Write registers through cfg_we/cfg_addr/cfg_wdata only while idle; the
// block itself does not enforce this. Synchronous active-low reset clears
// the run sums and the sequencer and restores register defaults (radius 1.0,
// cutoff 0.25, far max).
// s_axis_tdata: query_x[31:0], query_y[63:32], point_x[95:64],
// point_y[127:96], point_valid[128], zero fill to 136.
// m_axis_tdata: distance[31:0], no_neighbor[32], overflow[33], zero fill.
module weighted_mean_surface_distance (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // query_x, query_y, point_x, point_y, point_valid
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // distance, no_neighbor, overflow
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [30:0]  cfg_wdata
);
    logic [30:0] radius_reg;
    logic [16:0] cutoff_reg;
    logic [30:0] far_reg;
    logic [33:0] result;
    wmsd_pkg::wmsd_cmd_t cmd;
    wmsd_pkg::wmsd_sts_t sts;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 31'd65536;
            cutoff_reg <= 17'd16384;
            far_reg <= 31'h7FFFFFFF;
        end else if (cfg_we) begin
            if (cfg_addr == wmsd_pkg::REG_RADIUS) radius_reg <= cfg_wdata;
            if (cfg_addr == wmsd_pkg::REG_CUTOFF) cutoff_reg <= cfg_wdata[16:0];
            if (cfg_addr == wmsd_pkg::REG_FAR) far_reg <= cfg_wdata;
        end
    end

    wmsd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_last(s_axis_tlast),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .sts(sts), .cmd(cmd)
    );

    wmsd_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .kernel_radius(radius_reg), .cutoff_threshold(cutoff_reg), .far_value(far_reg),
        .qx_in(s_axis_tdata[31:0]), .qy_in(s_axis_tdata[63:32]),
        .px_in(s_axis_tdata[95:64]), .py_in(s_axis_tdata[127:96]),
        .pvalid_in(s_axis_tdata[128]), .result(result)
    );

    assign m_axis_tdata = {6'd0, result};
endmodule
